FILE: rtl/wob_pkg.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator bank package
// Shared types, operation codes, register map codes and address helpers.
// ----------------------------------------------------------------------------
package wob_pkg;

  // One oscillator's register-file entry.
  typedef struct packed {
    logic [15:0] rate;
    logic [7:0]  volume;
    logic [7:0]  page;
    logic [7:0]  mode;
    logic [7:0]  tbl;
    logic [31:0] phase;
  } osc_word_t;

  // Host operation codes.
  localparam logic [3:0] OP_WR_CTRL = 4'd0;
  localparam logic [3:0] OP_WR_LO   = 4'd1;
  localparam logic [3:0] OP_WR_HI   = 4'd2;
  localparam logic [3:0] OP_WR_DATA = 4'd3;
  localparam logic [3:0] OP_RD_CTRL = 4'd4;
  localparam logic [3:0] OP_RD_LO   = 4'd5;
  localparam logic [3:0] OP_RD_HI   = 4'd6;
  localparam logic [3:0] OP_RD_DATA = 4'd7;
  localparam logic [3:0] OP_TICK    = 4'd8;

  // Register groups, taken from bits 7..5 of the low pointer byte.
  localparam logic [2:0] GRP_RATE_LO = 3'd0;
  localparam logic [2:0] GRP_RATE_HI = 3'd1;
  localparam logic [2:0] GRP_VOLUME  = 3'd2;
  localparam logic [2:0] GRP_SAMPLE  = 3'd3;
  localparam logic [2:0] GRP_PAGE    = 3'd4;
  localparam logic [2:0] GRP_MODE    = 3'd5;
  localparam logic [2:0] GRP_TABLE   = 3'd6;
  localparam logic [2:0] GRP_GLOBAL  = 3'd7;

  // Global registers.
  localparam logic [7:0] REG_IRQ    = 8'hE0;
  localparam logic [7:0] REG_ACTIVE = 8'hE1;
  localparam logic [7:0] REG_ID     = 8'hE2;

  localparam logic [7:0] IRQ_FOUND = 8'h41;
  localparam logic [7:0] IRQ_NONE  = 8'hC1;
  localparam logic [7:0] ID_VALUE  = 8'd128;

  // Oscillator modes, mode bits 2..1.
  localparam logic [1:0] MODE_FREE    = 2'd0;
  localparam logic [1:0] MODE_ONESHOT = 2'd1;
  localparam logic [1:0] MODE_SYNC    = 2'd2;
  localparam logic [1:0] MODE_SWAP    = 2'd3;

  localparam int unsigned CTRL_WAVE_BIT = 6;
  localparam int unsigned CTRL_INC_BIT  = 5;
  localparam int unsigned MODE_HALT_BIT = 0;
  localparam int unsigned MODE_IE_BIT   = 3;

  localparam logic [7:0]  AMP_FULL   = 8'd255;
  localparam logic [16:0] DIV255_MUL = 17'd32897;
  localparam int unsigned MIX_W      = 22;
  localparam int unsigned SCALE_W    = MIX_W + 16;
  localparam int unsigned OUT_SHIFT  = 20;
  localparam int unsigned CNT_W      = 6;

  // Mask of the phase bits that count as overflow for a given resolution.
  function automatic logic [31:0] ovf_mask(logic [7:0] tbl);
    return ~(32'h00FF_FFFF >> (3'd7 - tbl[2:0]));
  endfunction

  // Wave memory address of an oscillator's current sample.
  function automatic logic [15:0] sample_addr(logic [7:0] page, logic [7:0] tbl,
                                              logic [31:0] phase);
    logic [3:0]  shift;
    logic [4:0]  sh;
    logic [15:0] tmask;
    logic [31:0] ptr;
    shift = 4'd8 - {1'b0, tbl[5:3]};
    tmask = 16'hFFFF >> shift;
    sh    = {2'b00, tbl[2:0]} + {1'b0, shift};
    ptr   = phase >> sh;
    return ({page, 8'h00} & ~tmask) | (ptr[15:0] & tmask);
  endfunction

endpackage

FILE: rtl/wavetable_oscillator_bank_core.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator bank core
// Host byte port, oscillator sequencer and mixer over shared memories.
// ----------------------------------------------------------------------------
// Control, pointer, wave write, global, out-of-range and sample write accesses
// give done_o in the cycle after start; register accesses pass S_REG_RD and
// S_REG_USE, sample reads also S_SMP. A tick walks the active oscillators one
// by one through the register file and wave memory, skipping halted ones, and
// mixes and saturates the voices. Reset clears all control state at once.
// Results are a one-cycle strobe on done_o; the receiver cannot stall.
module wavetable_oscillator_bank_core import wob_pkg::*; #(
  parameter int unsigned NUM_OSCILLATORS = 32,
  parameter int unsigned WAVE_ADDR_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  input  logic [3:0]         operation_i,
  input  logic [7:0]         write_value_i,
  output logic [7:0]         read_value_o,
  output logic signed [15:0] sample_out_o,
  output logic               sample_valid_o,
  output logic               irq_line_o,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i
);

  localparam int unsigned IdxW = (NUM_OSCILLATORS > 1) ? $clog2(NUM_OSCILLATORS) : 1;
  localparam int unsigned AW   = WAVE_ADDR_BITS;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_REG_RD  = 4'd1;
  localparam logic [3:0] S_REG_USE = 4'd2;
  localparam logic [3:0] S_SMP     = 4'd3;
  localparam logic [3:0] S_T_RD    = 4'd4;
  localparam logic [3:0] S_T_UPD   = 4'd5;
  localparam logic [3:0] S_T_AM    = 4'd6;
  localparam logic [3:0] S_T_LVL   = 4'd7;
  localparam logic [3:0] S_T_MUL   = 4'd8;
  localparam logic [3:0] S_T_DIV   = 4'd9;
  localparam logic [3:0] S_T_ACC   = 4'd10;
  localparam logic [3:0] S_T_SCALE = 4'd11;
  localparam logic [3:0] S_T_OUT   = 4'd12;

  logic [3:0]  state_q, state_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [15:0] ptr_q, ptr_d;
  logic [14:0] range_q;
  logic [CNT_W-1:0] active_q, active_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]  amp_q, amp_d;
  logic [NUM_OSCILLATORS-1:0] halt_q, halt_d, ie_q, ie_d, pend_q, pend_d;
  logic [7:0]  addr_q, addr_d, wv_q, wv_d;
  logic        is_rd_q, is_rd_d;
  logic [7:0]  vol_q, vol_d;
  logic signed [19:0] prod1_q, prod1_d;
  logic        neg_q, neg_d;
  logic [23:0] prod2_q, prod2_d;
  logic [15:0] q0_q, q0_d;
  logic signed [MIX_W-1:0]   mix_q, mix_d;
  logic signed [SCALE_W-1:0] scaled_q, scaled_d;
  logic        done_q, done_d, sv_q, sv_d;
  logic [7:0]  rdv_q, rdv_d;
  logic signed [15:0] smp_q, smp_d;

  // Memory ports.
  osc_word_t       osc_rd, osc_wr;
  logic [IdxW-1:0] osc_raddr, osc_waddr, pz_addr;
  logic            osc_we, pz_set;
  logic            wave_we;
  logic [AW-1:0]   wave_waddr, wave_raddr;
  logic [7:0]      wave_rd;

  // Helper values.
  logic [IdxW-1:0] ci, hn;
  logic [4:0]      reg_n;
  logic [2:0]      reg_grp;
  logic            n_out;
  logic            last_osc;
  logic [NUM_OSCILLATORS-1:0] act_mask, irq_vec;
  logic            irq_found;
  logic [IdxW-1:0] irq_idx;
  logic [31:0]     ph_sum, ov, new_ph;
  logic            hit;
  logic [40:0]     div_prod;
  logic [23:0]     q0_x255;
  logic [15:0]     quot;
  logic signed [10:0] lvl_s, vol_s;
  logic [19:0]     mag;
  logic signed [SCALE_W-OUT_SHIFT-1:0] shifted;
  logic [7:0]      mode_rd;

  wob_osc_ram #(
    .NumOsc (NUM_OSCILLATORS),
    .IdxW   (IdxW)
  ) u_osc_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (osc_raddr),
    .rd_data_o (osc_rd),
    .wr_en_i   (osc_we),
    .wr_addr_i (osc_waddr),
    .wr_data_i (osc_wr),
    .pz_set_i  (pz_set),
    .pz_addr_i (pz_addr)
  );

  wob_wave_ram #(
    .AddrW (AW)
  ) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (wave_we),
    .waddr_i (wave_waddr),
    .wdata_i (write_value_i),
    .raddr_i (wave_raddr),
    .rdata_o (wave_rd)
  );

  // Active oscillator mask and interrupt summary.
  always_comb begin
    for (int i = 0; i < NUM_OSCILLATORS; i++) begin
      act_mask[i] = (CNT_W'(i) < active_q);
    end
    irq_vec   = pend_q & ie_q & act_mask;
    irq_found = |irq_vec;
    irq_idx   = '0;
    for (int i = NUM_OSCILLATORS - 1; i >= 0; i--) begin
      if (irq_vec[i]) begin
        irq_idx = IdxW'(i);
      end
    end
  end

  assign ci       = cnt_q[IdxW-1:0];
  assign last_osc = ((cnt_q + CNT_W'(1)) >= active_q);
  assign reg_n    = ptr_q[4:0];
  assign reg_grp  = ptr_q[7:5];
  assign n_out    = ({1'b0, reg_n} >= CNT_W'(NUM_OSCILLATORS));
  assign hn       = reg_n[IdxW-1:0];

  // Oscillator step arithmetic.
  always_comb begin
    ph_sum = osc_rd.phase + {16'h0000, osc_rd.rate};
    ov     = ovf_mask(osc_rd.tbl);
    hit    = |(ph_sum & ov);
    mode_rd = osc_rd.mode;
    mode_rd[MODE_HALT_BIT] = halt_q[addr_q[IdxW-1:0]];
    mode_rd[MODE_IE_BIT]   = ie_q[addr_q[IdxW-1:0]];
    lvl_s    = $signed({3'b000, wave_rd}) - 11'sd128;
    vol_s    = $signed({3'b000, vol_q});
    mag      = prod1_q[19] ? 20'(-prod1_q) : 20'(prod1_q);
    div_prod = 41'(prod2_q) * 41'(DIV255_MUL);
    q0_x255  = {q0_q, 8'h00} - 24'(q0_q);
    quot     = (q0_x255 > prod2_q) ? (q0_q - 16'd1) : q0_q;
    shifted  = scaled_q[SCALE_W-1:OUT_SHIFT];
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    ctrl_d   = ctrl_q;
    ptr_d    = ptr_q;
    active_d = active_q;
    cnt_d    = cnt_q;
    amp_d    = amp_q;
    halt_d   = halt_q;
    ie_d     = ie_q;
    pend_d   = pend_q;
    addr_d   = addr_q;
    wv_d     = wv_q;
    is_rd_d  = is_rd_q;
    vol_d    = vol_q;
    prod1_d  = prod1_q;
    neg_d    = neg_q;
    prod2_d  = prod2_q;
    q0_d     = q0_q;
    mix_d    = mix_q;
    scaled_d = scaled_q;
    done_d   = 1'b0;
    rdv_d    = 8'h00;
    smp_d    = 16'sd0;
    sv_d     = 1'b0;
    new_ph   = ph_sum;
    osc_raddr  = ci;
    osc_we     = 1'b0;
    osc_waddr  = ci;
    osc_wr     = osc_rd;
    pz_set     = 1'b0;
    pz_addr    = IdxW'(cnt_q + CNT_W'(1));
    wave_we    = 1'b0;
    wave_waddr = AW'(ptr_q);
    wave_raddr = AW'(sample_addr(osc_rd.page, osc_rd.tbl, osc_rd.phase));

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          addr_d = ptr_q[7:0];
          wv_d   = write_value_i;
          unique case (operation_i)
            OP_WR_CTRL: begin
              ctrl_d = write_value_i;
              done_d = 1'b1;
            end
            OP_WR_LO: begin
              ptr_d[7:0] = write_value_i;
              done_d     = 1'b1;
            end
            OP_WR_HI: begin
              ptr_d[15:8] = write_value_i;
              done_d      = 1'b1;
            end
            OP_RD_CTRL: begin
              rdv_d  = ctrl_q;
              done_d = 1'b1;
            end
            OP_RD_LO: begin
              rdv_d  = ptr_q[7:0];
              done_d = 1'b1;
            end
            OP_RD_HI: begin
              rdv_d  = ptr_q[15:8];
              done_d = 1'b1;
            end
            OP_WR_DATA: begin
              if (ctrl_q[CTRL_INC_BIT]) begin
                ptr_d = ptr_q + 16'd1;
              end
              is_rd_d = 1'b0;
              if (ctrl_q[CTRL_WAVE_BIT]) begin
                wave_we = 1'b1;
                done_d  = 1'b1;
              end else if (reg_grp == GRP_GLOBAL) begin
                if (ptr_q[7:0] == REG_ACTIVE) begin
                  active_d = ({1'b0, write_value_i[5:1]} + CNT_W'(1) >
                              CNT_W'(NUM_OSCILLATORS)) ? CNT_W'(NUM_OSCILLATORS)
                             : ({1'b0, write_value_i[5:1]} + CNT_W'(1));
                end
                done_d = 1'b1;
              end else if (n_out || reg_grp == GRP_SAMPLE) begin
                done_d = 1'b1;
              end else begin
                if (reg_grp == GRP_MODE) begin
                  halt_d[hn] = write_value_i[MODE_HALT_BIT];
                  ie_d[hn]   = write_value_i[MODE_IE_BIT];
                end
                state_d = S_REG_RD;
              end
            end
            OP_RD_DATA: begin
              if (ctrl_q[CTRL_INC_BIT]) begin
                ptr_d = ptr_q + 16'd1;
              end
              is_rd_d = 1'b1;
              if (reg_grp == GRP_GLOBAL) begin
                done_d = 1'b1;
                if (ptr_q[7:0] == REG_IRQ) begin
                  if (irq_found) begin
                    rdv_d           = IRQ_FOUND | 8'({irq_idx, 1'b0});
                    pend_d[irq_idx] = 1'b0;
                  end else begin
                    rdv_d = IRQ_NONE;
                  end
                end else if (ptr_q[7:0] == REG_ACTIVE) begin
                  rdv_d = 8'({active_q - CNT_W'(1), 1'b0});
                end else if (ptr_q[7:0] == REG_ID) begin
                  rdv_d = ID_VALUE;
                end
              end else if (n_out) begin
                done_d = 1'b1;
              end else begin
                state_d = S_REG_RD;
              end
            end
            OP_TICK: begin
              cnt_d   = '0;
              mix_d   = '0;
              state_d = S_T_RD;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Fetch the addressed oscillator's entry.
      S_REG_RD: begin
        osc_raddr = addr_q[IdxW-1:0];
        state_d   = S_REG_USE;
      end

      S_REG_USE: begin
        osc_waddr = addr_q[IdxW-1:0];
        if (is_rd_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          case (addr_q[7:5])
            GRP_RATE_LO: rdv_d = osc_rd.rate[7:0];
            GRP_RATE_HI: rdv_d = osc_rd.rate[15:8];
            GRP_VOLUME:  rdv_d = osc_rd.volume;
            GRP_PAGE:    rdv_d = osc_rd.page;
            GRP_MODE:    rdv_d = mode_rd;
            GRP_SAMPLE: begin
              done_d  = 1'b0;
              state_d = S_SMP;
            end
            default:     rdv_d = osc_rd.tbl;
          endcase
        end else begin
          osc_we = 1'b1;
          case (addr_q[7:5])
            GRP_RATE_LO: osc_wr.rate[7:0]  = wv_q;
            GRP_RATE_HI: osc_wr.rate[15:8] = wv_q;
            GRP_VOLUME:  osc_wr.volume     = wv_q;
            GRP_PAGE:    osc_wr.page       = wv_q;
            GRP_MODE:    osc_wr.mode       = wv_q;
            default:     osc_wr.tbl        = wv_q;
          endcase
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_SMP: begin
        rdv_d   = wave_rd;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      // Skip halted oscillators, else fetch the entry.
      S_T_RD: begin
        if (halt_q[ci]) begin
          if (last_osc) begin
            state_d = S_T_SCALE;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end else begin
          state_d = S_T_UPD;
        end
      end

      // Advance the phase, apply the mode and start the sample fetch.
      S_T_UPD: begin
        vol_d = osc_rd.volume;
        state_d = S_T_LVL;
        case (osc_rd.mode[2:1])
          MODE_ONESHOT: begin
            if (hit) begin
              new_ph     = '0;
              halt_d[ci] = 1'b1;
              pend_d[ci] = 1'b1;
            end
          end
          MODE_SYNC: begin
            if (ci[0]) begin
              state_d = S_T_AM;
            end else if (hit) begin
              new_ph = ph_sum & ~ov;
              pz_set = ((cnt_q + CNT_W'(1)) < CNT_W'(NUM_OSCILLATORS));
            end
          end
          MODE_SWAP: begin
            if (hit) begin
              new_ph     = '0;
              halt_d[ci] = 1'b1;
              pend_d[ci] = 1'b1;
              if ({1'b0, cnt_q ^ CNT_W'(1)} < {1'b0, CNT_W'(NUM_OSCILLATORS)}) begin
                halt_d[ci ^ IdxW'(1)] = 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
        osc_we       = 1'b1;
        osc_wr.phase = new_ph;
        wave_raddr   = AW'(sample_addr(osc_rd.page, osc_rd.tbl, new_ph));
        if (state_d == S_T_LVL && halt_d[ci]) begin
          if (last_osc) begin
            state_d = S_T_SCALE;
          end else begin
            cnt_d   = cnt_q + CNT_W'(1);
            state_d = S_T_RD;
          end
        end
      end

      // Modulation source: its sample weights the next voice.
      S_T_AM: begin
        amp_d = wave_rd;
        if (last_osc) begin
          state_d = S_T_SCALE;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_T_RD;
        end
      end

      // Zero sample halts the voice, else weight by volume.
      S_T_LVL: begin
        if (wave_rd == 8'h00) begin
          halt_d[ci] = 1'b1;
          amp_d      = AMP_FULL;
          if (last_osc) begin
            state_d = S_T_SCALE;
          end else begin
            cnt_d   = cnt_q + CNT_W'(1);
            state_d = S_T_RD;
          end
        end else begin
          prod1_d = 20'(lvl_s * vol_s);
          state_d = S_T_MUL;
        end
      end

      S_T_MUL: begin
        neg_d   = prod1_q[19];
        prod2_d = 24'(mag[15:0] * amp_q);
        state_d = S_T_DIV;
      end

      // Divide by 255 through a reciprocal, corrected in the next step.
      S_T_DIV: begin
        q0_d    = div_prod[38:23];
        state_d = S_T_ACC;
      end

      S_T_ACC: begin
        mix_d = neg_q ? (mix_q - $signed(MIX_W'(quot))) : (mix_q + $signed(MIX_W'(quot)));
        amp_d = AMP_FULL;
        if (last_osc) begin
          state_d = S_T_SCALE;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_T_RD;
        end
      end

      S_T_SCALE: begin
        scaled_d = mix_q * $signed({1'b0, range_q});
        state_d  = S_T_OUT;
      end

      // Floor shift and saturation.
      S_T_OUT: begin
        if (shifted > 18'sd32767) begin
          smp_d = 16'sh7FFF;
        end else if (shifted < -18'sd32768) begin
          smp_d = -16'sh8000;
        end else begin
          smp_d = shifted[15:0];
        end
        sv_d    = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ctrl_q   <= 8'h00;
      ptr_q    <= 16'h0000;
      range_q  <= 15'h7FFF;
      active_q <= CNT_W'(1);
      cnt_q    <= '0;
      amp_q    <= AMP_FULL;
      halt_q   <= '1;
      ie_q     <= '0;
      pend_q   <= '0;
      done_q   <= 1'b0;
      sv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ctrl_q   <= ctrl_d;
      ptr_q    <= ptr_d;
      if (cfg_we_i) begin
        range_q <= cfg_wdata_i;
      end
      active_q <= active_d;
      cnt_q    <= cnt_d;
      amp_q    <= amp_d;
      halt_q   <= halt_d;
      ie_q     <= ie_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
      sv_q     <= sv_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    wv_q     <= wv_d;
    is_rd_q  <= is_rd_d;
    vol_q    <= vol_d;
    prod1_q  <= prod1_d;
    neg_q    <= neg_d;
    prod2_q  <= prod2_d;
    q0_q     <= q0_d;
    mix_q    <= mix_d;
    scaled_q <= scaled_d;
    rdv_q    <= rdv_d;
    smp_q    <= smp_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign read_value_o   = rdv_q;
  assign sample_out_o   = smp_q;
  assign sample_valid_o = sv_q;
  assign irq_line_o     = irq_found;

endmodule

FILE: rtl/wob_wave_ram.sv
// ----------------------------------------------------------------------------
// Wave memory
// Single write port, single registered read port sample store.
// ----------------------------------------------------------------------------
module wob_wave_ram #(
  parameter int unsigned AddrW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [2**AddrW];
  logic [7:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/wob_osc_ram.sv
// ----------------------------------------------------------------------------
// Oscillator register file
// One entry per oscillator with per-entry valid and phase-zero flags.
// ----------------------------------------------------------------------------
module wob_osc_ram import wob_pkg::*; #(
  parameter int unsigned NumOsc = 32,
  parameter int unsigned IdxW   = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] rd_addr_i,
  output osc_word_t       rd_data_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  osc_word_t       wr_data_i,
  input  logic            pz_set_i,
  input  logic [IdxW-1:0] pz_addr_i
);

  osc_word_t        mem_q [NumOsc];
  osc_word_t        rd_q;
  logic [NumOsc-1:0] valid_q, pz_q;
  logic             rd_valid_q, rd_pz_q;

  // Storage, read every cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // Entry flags: unwritten entries read as reset, zeroed phases read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      pz_q       <= '0;
      rd_valid_q <= 1'b0;
      rd_pz_q    <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
      rd_pz_q    <= pz_q[rd_addr_i];
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
        pz_q[wr_addr_i]    <= 1'b0;
      end
      if (pz_set_i) begin
        pz_q[pz_addr_i] <= 1'b1;
      end
    end
  end

  always_comb begin
    rd_data_o = rd_valid_q ? rd_q : '0;
    if (rd_pz_q) begin
      rd_data_o.phase = '0;
    end
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator bank core testbench
// Drives host bus transactions and sample ticks into the core and checks every
// result strobe against a cycle-free predictor of the oscillator bank. A short
// directed table comes first, the first wave page filled within it; random
// traffic runs under several output range settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wob_pkg::*;

  localparam int unsigned NOSC       = 32;
  localparam int unsigned SETTLE_CYC = 250;
  localparam int unsigned RAND_ITEMS = 200;
  localparam int unsigned FILL_AT    = 15;
  localparam int unsigned FILL_BYTES = 256;

  typedef struct packed {
    logic [7:0]         rd;
    logic signed [15:0] smp;
    logic               val;
    logic               irq;
  } bus_result_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  wv;
    logic        typed;
    bus_result_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic done_o;
  logic [3:0] operation_i = '0;
  logic [7:0] write_value_i = '0;
  logic [7:0] read_value_o;
  logic signed [15:0] sample_out_o;
  logic sample_valid_o;
  logic irq_line_o;
  logic cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;

  // Predicted state of the bank.
  logic [7:0]  p_wave [65536];
  logic [15:0] p_rate [NOSC];
  logic [7:0]  p_vol  [NOSC];
  logic [7:0]  p_page [NOSC];
  logic [7:0]  p_mode [NOSC];
  logic [7:0]  p_tbl  [NOSC];
  logic [31:0] p_phase[NOSC];
  logic        p_pend [NOSC];
  int unsigned p_count;
  logic [7:0]  p_ctrl;
  logic [15:0] p_ptr;
  logic [7:0]  p_modamp;
  logic [14:0] p_range;

  bus_result_t pending_results[$];
  int errors = 0;
  int n_ticks = 0;
  int n_checked = 0;

  wavetable_oscillator_bank_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .operation_i   (operation_i),
    .write_value_i (write_value_i),
    .read_value_o  (read_value_o),
    .sample_out_o  (sample_out_o),
    .sample_valid_o(sample_valid_o),
    .irq_line_o    (irq_line_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Current wave sample of one oscillator.
  function automatic logic [7:0] voice_sample(int c);
    int sh;
    logic [15:0] tm;
    logic [31:0] ptr;
    logic [15:0] a;
    sh  = 8 - int'(p_tbl[c][5:3]);
    tm  = 16'hFFFF >> sh;
    ptr = p_phase[c] >> (int'(p_tbl[c][2:0]) + sh);
    a   = ({p_page[c], 8'h00} & ~tm) | (ptr[15:0] & tm);
    return p_wave[a];
  endfunction

  function automatic void regfile_write(logic [7:0] a, logic [7:0] v);
    int n;
    int unsigned cnt;
    n = int'(a[4:0]);
    case (a[7:5])
      GRP_RATE_LO: p_rate[n][7:0] = v;
      GRP_RATE_HI: p_rate[n][15:8] = v;
      GRP_VOLUME:  p_vol[n] = v;
      GRP_PAGE:    p_page[n] = v;
      GRP_MODE:    p_mode[n] = v;
      GRP_TABLE:   p_tbl[n] = v;
      GRP_GLOBAL: begin
        if (a == REG_ACTIVE) begin
          cnt = 1 + v[5:1];
          p_count = (cnt > NOSC) ? NOSC : cnt;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] regfile_read(logic [7:0] a);
    int n;
    n = int'(a[4:0]);
    case (a[7:5])
      GRP_RATE_LO: return p_rate[n][7:0];
      GRP_RATE_HI: return p_rate[n][15:8];
      GRP_VOLUME:  return p_vol[n];
      GRP_SAMPLE:  return voice_sample(n);
      GRP_PAGE:    return p_page[n];
      GRP_MODE:    return p_mode[n];
      GRP_TABLE:   return p_tbl[n];
      default: begin
        if (a == REG_IRQ) begin
          for (int c = 0; c < p_count; c++) begin
            if (p_pend[c] && p_mode[c][MODE_IE_BIT]) begin
              p_pend[c] = 1'b0;
              return IRQ_FOUND | 8'(c << 1);
            end
          end
          return IRQ_NONE;
        end
        if (a == REG_ACTIVE) return 8'((p_count - 1) << 1);
        if (a == REG_ID) return ID_VALUE;
        return 8'h00;
      end
    endcase
  endfunction

  // One sample tick: step the running oscillators and mix their output.
  function automatic logic signed [15:0] mix_tick();
    longint acc;
    longint sc;
    int v;
    logic [31:0] ovm;
    logic [7:0] lvl;
    acc = 0;
    for (int c = 0; c < p_count; c++) begin
      if (p_mode[c][MODE_HALT_BIT]) continue;
      p_phase[c] += 32'(p_rate[c]);
      ovm = ~(32'h00FF_FFFF >> (7 - int'(p_tbl[c][2:0])));
      case (p_mode[c][2:1])
        MODE_ONESHOT: begin
          if (|(p_phase[c] & ovm)) begin
            p_phase[c] = '0;
            p_mode[c][MODE_HALT_BIT] = 1'b1;
            p_pend[c] = 1'b1;
          end
        end
        MODE_SYNC: begin
          // An odd oscillator only sets the amplitude of the next voice.
          if (c % 2 == 1) begin
            p_modamp = voice_sample(c);
            continue;
          end
          if (|(p_phase[c] & ovm)) begin
            p_phase[c] &= ~ovm;
            if (c + 1 < NOSC) p_phase[c + 1] = '0;
          end
        end
        MODE_SWAP: begin
          if (|(p_phase[c] & ovm)) begin
            p_mode[c][MODE_HALT_BIT] = 1'b1;
            p_phase[c] = '0;
            p_pend[c] = 1'b1;
            p_mode[c ^ 1][MODE_HALT_BIT] = 1'b0;
          end
        end
        default: ;
      endcase
      if (p_mode[c][MODE_HALT_BIT]) continue;
      lvl = voice_sample(c);
      if (lvl == 8'h00) begin
        p_mode[c][MODE_HALT_BIT] = 1'b1;
        v = 0;
      end else begin
        v = (int'(lvl) - 128) * int'(p_vol[c]);
        v = (v * int'(p_modamp)) / 255;
      end
      acc += v;
      p_modamp = AMP_FULL;
    end
    sc = acc * longint'(p_range);
    if (sc < 0) sc = -(((-sc) + 1048575) / 1048576);
    else sc = sc / 1048576;
    if (sc > 32767) sc = 32767;
    if (sc < -32768) sc = -32768;
    return 16'(sc);
  endfunction

  function automatic bus_result_t predict_step(logic [3:0] op, logic [7:0] wv);
    bus_result_t r;
    logic [15:0] a;
    r = '0;
    case (op)
      OP_WR_CTRL: p_ctrl = wv;
      OP_WR_LO:   p_ptr[7:0] = wv;
      OP_WR_HI:   p_ptr[15:8] = wv;
      OP_WR_DATA: begin
        if (p_ctrl[CTRL_WAVE_BIT]) p_wave[p_ptr] = wv;
        else regfile_write(p_ptr[7:0], wv);
        if (p_ctrl[CTRL_INC_BIT]) p_ptr = p_ptr + 16'd1;
      end
      OP_RD_CTRL: r.rd = p_ctrl;
      OP_RD_LO:   r.rd = p_ptr[7:0];
      OP_RD_HI:   r.rd = p_ptr[15:8];
      OP_RD_DATA: begin
        a = p_ptr;
        if (p_ctrl[CTRL_INC_BIT]) p_ptr = p_ptr + 16'd1;
        r.rd = regfile_read(a[7:0]);
      end
      OP_TICK: begin
        r.smp = mix_tick();
        r.val = 1'b1;
      end
      default: ;
    endcase
    for (int c = 0; c < p_count; c++)
      if (p_pend[c] && p_mode[c][MODE_IE_BIT]) r.irq = 1'b1;
    return r;
  endfunction

  // Compare each result strobe with the oldest expected transaction.
  always @(posedge clk_i) begin
    bus_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result rd=%h smp=%0d val=%b irq=%b", $time,
                 read_value_o, sample_out_o, sample_valid_o, irq_line_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (read_value_o !== want.rd) begin
          $display("%0t: read_value expected %h actual %h", $time, want.rd, read_value_o);
          errors++;
        end
        if (sample_out_o !== want.smp) begin
          $display("%0t: sample_out expected %0d actual %0d", $time, want.smp, sample_out_o);
          errors++;
        end
        if (sample_valid_o !== want.val) begin
          $display("%0t: sample_valid expected %b actual %b", $time, want.val,
                   sample_valid_o);
          errors++;
        end
        if (irq_line_o !== want.irq) begin
          $display("%0t: irq_line expected %b actual %b", $time, want.irq, irq_line_o);
          errors++;
        end
      end
    end
  end

  // Issue one transaction; entered and left just after a rising edge.
  task automatic send_item(input logic [3:0] op, input logic [7:0] wv, input bit typed,
                           input bus_result_t res, input int idle_pct);
    bus_result_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    operation_i   <= op;
    write_value_i <= wv;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    pred = predict_step(op, wv);
    if (op == OP_TICK) n_ticks++;
    pending_results.push_back(typed ? res : pred);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_range(input logic [14:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    p_range = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_item(input int idle_pct);
    int r;
    logic [3:0] op;
    logic [7:0] wv;
    r  = $urandom_range(99);
    wv = 8'($urandom);
    if (r < 30) op = OP_TICK;
    else if (r < 55) op = OP_WR_DATA;
    else if (r < 70) op = OP_WR_LO;
    else if (r < 74) op = OP_WR_HI;
    else if (r < 80) begin
      // Mostly register-file access; wave memory writes now and then.
      op = OP_WR_CTRL;
      if ($urandom_range(7) != 0) wv[CTRL_WAVE_BIT] = 1'b0;
    end else if (r < 95) op = 4'($urandom_range(4, 7));
    else op = 4'($urandom_range(9, 15));
    // Keep every voice inside the filled first wave page.
    if (op == OP_WR_DATA && !p_ctrl[CTRL_WAVE_BIT]) begin
      if (p_ptr[7:5] == GRP_PAGE) wv = 8'h00;
      else if (p_ptr[7:5] == GRP_TABLE) wv[5:3] = 3'b000;
    end
    send_item(op, wv, 1'b0, '0, idle_pct);
  endtask

  stim_row_t rows[] = '{
    '{OP_RD_CTRL, 8'h00, 1'b1, '{8'h00, 16'sd0, 1'b0, 1'b0}},
    '{OP_RD_LO,   8'h00, 1'b1, '{8'h00, 16'sd0, 1'b0, 1'b0}},
    '{OP_RD_HI,   8'h00, 1'b1, '{8'h00, 16'sd0, 1'b0, 1'b0}},
    '{OP_WR_LO,   REG_ID, 1'b1, '{8'h00, 16'sd0, 1'b0, 1'b0}},
    '{OP_RD_DATA, 8'h00, 1'b1, '{ID_VALUE, 16'sd0, 1'b0, 1'b0}},
    '{OP_WR_LO,   REG_ACTIVE, 1'b1, '{8'h00, 16'sd0, 1'b0, 1'b0}},
    '{OP_RD_DATA, 8'h00, 1'b1, '{8'h00, 16'sd0, 1'b0, 1'b0}},
    '{OP_WR_LO,   REG_IRQ, 1'b1, '{8'h00, 16'sd0, 1'b0, 1'b0}},
    '{OP_RD_DATA, 8'h00, 1'b1, '{IRQ_NONE, 16'sd0, 1'b0, 1'b0}},
    '{OP_TICK,    8'h00, 1'b1, '{8'h00, 16'sd0, 1'b1, 1'b0}},
    '{4'd9,       8'hFF, 1'b1, '{8'h00, 16'sd0, 1'b0, 1'b0}},
    '{4'd15,      8'hFF, 1'b1, '{8'h00, 16'sd0, 1'b0, 1'b0}},
    '{OP_WR_LO,   REG_ACTIVE, 1'b1, '{8'h00, 16'sd0, 1'b0, 1'b0}},
    '{OP_WR_DATA, 8'hFF, 1'b1, '{8'h00, 16'sd0, 1'b0, 1'b0}},
    '{OP_RD_DATA, 8'h00, 1'b1, '{8'h3E, 16'sd0, 1'b0, 1'b0}},
    // After the wave fill: a one-shot voice with interrupt enable, full volume.
    '{OP_WR_CTRL, 8'h00, 1'b0, '0},
    '{OP_WR_LO,   8'h20, 1'b0, '0},
    '{OP_WR_DATA, 8'hFF, 1'b0, '0},
    '{OP_WR_LO,   8'h40, 1'b0, '0},
    '{OP_WR_DATA, 8'hFF, 1'b0, '0},
    '{OP_WR_LO,   8'hA0, 1'b0, '0},
    '{OP_WR_DATA, 8'h0A, 1'b0, '0},
    '{OP_TICK,    8'h00, 1'b0, '0},
    '{OP_TICK,    8'h00, 1'b0, '0},
    '{OP_TICK,    8'h00, 1'b0, '0},
    '{OP_WR_LO,   REG_IRQ, 1'b0, '0},
    '{OP_RD_DATA, 8'h00, 1'b0, '0},
    '{OP_WR_LO,   8'h60, 1'b0, '0},
    '{OP_RD_DATA, 8'h00, 1'b0, '0}
  };

  int idle_of_phase[5] = '{0, 82, 0, 37, 82};
  logic [14:0] range_of_phase[5];

  initial begin
    logic [7:0] b;
    for (int c = 0; c < NOSC; c++) begin
      p_rate[c] = '0; p_vol[c] = '0; p_page[c] = '0; p_mode[c] = 8'h01;
      p_tbl[c] = '0; p_phase[c] = '0; p_pend[c] = 1'b0;
    end
    p_count = 1; p_ctrl = '0; p_ptr = '0; p_modamp = AMP_FULL; p_range = 15'h7FFF;
    range_of_phase = '{15'h7FFF, 15'h0000, 15'h0001, 15'($urandom), 15'h7FFF};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, with the first wave page filled before row FILL_AT.
    foreach (rows[i]) begin
      if (i == FILL_AT) begin
        send_item(OP_WR_CTRL, 8'h60, 1'b0, '0, 0);
        send_item(OP_WR_LO, 8'h00, 1'b0, '0, 0);
        send_item(OP_WR_HI, 8'h00, 1'b0, '0, 0);
        for (int k = 0; k < FILL_BYTES; k++) begin
          b = ($urandom_range(63) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
          send_item(OP_WR_DATA, b, 1'b0, '0, 0);
        end
      end
      send_item(rows[i].op, rows[i].wv, rows[i].typed, rows[i].res, 0);
    end

    // Random traffic under each gain setting and idle pattern.
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        drain();
        write_range(range_of_phase[p]);
      end
      for (int k = 0; k < RAND_ITEMS; k++) begin
        if ((k / 40) % 3 == 2) random_item(0);
        else random_item(idle_of_phase[p]);
      end
    end
    drain();

    $display("tb: %0d results checked, %0d sample ticks, five output range settings",
             n_checked, n_ticks);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/wob_pkg.sv
rtl/wob_wave_ram.sv
rtl/wob_osc_ram.sv
rtl/wavetable_oscillator_bank_core.sv
verif/tb_top.sv
